>>> rtl/qmr_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and arithmetic helpers for the quaternion multiply/rotate unit
// no dependencies
package qmr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	// a 32x33 signed product fits in 65 bits; one more keeps the four-term sums exact
	localparam int PROD_W    = 66;
	localparam int SUM_W     = 66;
	localparam int NPROD     = 16;

	// command codes
	localparam logic CMD_PRODUCT = 1'b0;
	localparam logic CMD_ROTATE  = 1'b1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WORD_W:0]   negw_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef prod_t prod_arr_t [NPROD];
	typedef word_t quat_arr_t [4];

	typedef struct packed {
		word_t w;
		word_t x;
		word_t y;
		word_t z;
		logic  ovf;
	} ham_t;

	localparam sum_t SAT_MAX = SUM_W'(64'sh0000_0000_7fff_ffff);
	localparam sum_t SAT_MIN = -SAT_MAX - sum_t'(1);

	// floor division by 2^FRAC_BITS
	function automatic sum_t scl(prod_t p);
		return SUM_W'(p >>> FRAC_BITS);
	endfunction

	// products indexed as p[i*4+j] = lhs[i] * rhs[j], components ordered w, x, y, z
	function automatic ham_t combine(prod_arr_t p);
		sum_t  s [4];
		word_t o [4];
		ham_t  r;
		s[0] = scl(p[0]) - scl(p[5]) - scl(p[10]) - scl(p[15]);
		s[1] = scl(p[1]) + scl(p[4]) + scl(p[11]) - scl(p[14]);
		s[2] = scl(p[2]) - scl(p[7]) + scl(p[8])  + scl(p[13]);
		s[3] = scl(p[3]) + scl(p[6]) - scl(p[9])  + scl(p[12]);
		r.ovf = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (s[k] > SAT_MAX) begin
				o[k]  = WORD_W'(SAT_MAX);
				r.ovf = 1'b1;
			end else if (s[k] < SAT_MIN) begin
				o[k]  = WORD_W'(SAT_MIN);
				r.ovf = 1'b1;
			end else begin
				o[k] = WORD_W'(s[k]);
			end
		end
		r.w = o[0];
		r.x = o[1];
		r.y = o[2];
		r.z = o[3];
		return r;
	endfunction

endpackage

>>> rtl/quaternion_multiply_rotate_top.sv
`timescale 1ns / 1ps
// channel    | signals                                   | handshake
// -----------+-------------------------------------------+-----------------------------
// command    | cmd, a_w..a_z, b_w..b_z                   | start high, busy low
// result     | r_w, r_x, r_y, r_z, overflow              | done strobe, one cycle
//
// four register stages: products, sums, second products, sums and output select.
// a transaction may start every cycle; its result shows when it leaves the last stage.
// a product skips the second multiply but is carried along, so both commands pass through the same stages.
// busy is always low: with no stall on the result side nothing ever holds the pipe.
// arst_n clears the stage valid bits; data registers are not reset.
// depends on qmr_pkg
module quaternion_multiply_rotate_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  qmr_pkg::word_t       a_w,
	input  qmr_pkg::word_t       a_x,
	input  qmr_pkg::word_t       a_y,
	input  qmr_pkg::word_t       a_z,
	input  qmr_pkg::word_t       b_w,
	input  qmr_pkg::word_t       b_x,
	input  qmr_pkg::word_t       b_y,
	input  qmr_pkg::word_t       b_z,
	output logic                 done,
	output qmr_pkg::word_t       r_w,
	output qmr_pkg::word_t       r_x,
	output qmr_pkg::word_t       r_y,
	output qmr_pkg::word_t       r_z,
	output logic                 overflow
);

	logic accept;

	// stage 1: first set of products
	qmr_pkg::word_t     pa [4];
	qmr_pkg::word_t     qb [4];
	qmr_pkg::prod_arr_t prod1;
	qmr_pkg::prod_arr_t p_s1;
	qmr_pkg::quat_arr_t a_s1;
	logic               cmd_s1;
	logic               v_s1;

	// stage 2: first sums
	qmr_pkg::ham_t      h1;
	qmr_pkg::ham_t      h1_s2;
	qmr_pkg::quat_arr_t a_s2;
	logic               cmd_s2;
	logic               v_s2;

	// stage 3: products with the conjugate
	qmr_pkg::word_t     ta [4];
	qmr_pkg::negw_t     cj [4];
	qmr_pkg::prod_arr_t prod2;
	qmr_pkg::prod_arr_t p_s3;
	qmr_pkg::ham_t      h1_s3;
	logic               cmd_s3;
	logic               v_s3;

	// stage 4: second sums and output
	qmr_pkg::ham_t      h2;
	qmr_pkg::word_t     r_w_s4;
	qmr_pkg::word_t     r_x_s4;
	qmr_pkg::word_t     r_y_s4;
	qmr_pkg::word_t     r_z_s4;
	logic               ovf_s4;
	logic               v_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// rotate multiplies a by the pure quaternion (0, b_x, b_y, b_z)
	always_comb begin
		pa[0] = a_w;
		pa[1] = a_x;
		pa[2] = a_y;
		pa[3] = a_z;
		qb[0] = (cmd == qmr_pkg::CMD_ROTATE) ? '0 : b_w;
		qb[1] = b_x;
		qb[2] = b_y;
		qb[3] = b_z;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod1[i*4+j] = qmr_pkg::PROD_W'(pa[i]) * qmr_pkg::PROD_W'(qb[j]);
			end
		end
	end

	always_comb begin
		h1 = qmr_pkg::combine(p_s1);
	end

	// conjugate negation is exact in 33 bits, so -2^31 stays unsaturated
	always_comb begin
		ta[0] = h1_s2.w;
		ta[1] = h1_s2.x;
		ta[2] = h1_s2.y;
		ta[3] = h1_s2.z;
		cj[0] = qmr_pkg::negw_t'(a_s2[0]);
		cj[1] = -qmr_pkg::negw_t'(a_s2[1]);
		cj[2] = -qmr_pkg::negw_t'(a_s2[2]);
		cj[3] = -qmr_pkg::negw_t'(a_s2[3]);
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod2[i*4+j] = qmr_pkg::PROD_W'(ta[i]) * qmr_pkg::PROD_W'(cj[j]);
			end
		end
	end

	always_comb begin
		h2 = qmr_pkg::combine(p_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= prod1;
		a_s1    <= pa;
		cmd_s1  <= cmd;

		h1_s2   <= h1;
		a_s2    <= a_s1;
		cmd_s2  <= cmd_s1;

		p_s3    <= prod2;
		h1_s3   <= h1_s2;
		cmd_s3  <= cmd_s2;

		if (cmd_s3 == qmr_pkg::CMD_ROTATE) begin
			// scalar of the rotation is computed but dropped; its saturation still counts
			r_w_s4 <= '0;
			r_x_s4 <= h2.x;
			r_y_s4 <= h2.y;
			r_z_s4 <= h2.z;
			ovf_s4 <= h1_s3.ovf | h2.ovf;
		end else begin
			r_w_s4 <= h1_s3.w;
			r_x_s4 <= h1_s3.x;
			r_y_s4 <= h1_s3.y;
			r_z_s4 <= h1_s3.z;
			ovf_s4 <= h1_s3.ovf;
		end
	end

	assign done     = v_s4;
	assign r_w      = r_w_s4;
	assign r_x      = r_x_s4;
	assign r_y      = r_y_s4;
	assign r_z      = r_z_s4;
	assign overflow = ovf_s4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("transaction started without a result four cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without a matching transaction");

	a_rotate_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(cmd, 4) == qmr_pkg::CMD_ROTATE)) |-> (r_w == '0))
		else $error("rotate result has a nonzero scalar part");

endmodule
